>>> hw/rtl/idi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idi_pkg
// Shared types and constants of the inverse distance interpolator.
// ----------------------------------------------------------------------------
package idi_pkg;

  localparam int MAX_CHANNELS_DEF = 64;

  localparam int CRD_W = 16;   // Q2.14 coordinate
  localparam int VAL_W = 32;   // Q16.16 sample
  localparam int WGT_W = 24;   // weight after capping
  localparam int D2_W  = 34;   // squared distance
  localparam int DVD_W = 64;   // divider dividend and quotient
  localparam int DSR_W = 34;   // divider divisor
  localparam int STP_W = 7;    // divider step count
  localparam int RAD_W = 15;   // radius registers
  localparam int CNT_W = 7;    // channel_count register

  localparam logic [STP_W-1:0] STEPS_INV = 7'd41;
  localparam logic [STP_W-1:0] STEPS_SHA = 7'd50;
  localparam logic [STP_W-1:0] STEPS_SHB = 7'd41;
  localparam logic [STP_W-1:0] STEPS_FIN = 7'd64;

  localparam logic [1:0] MODE_POS   = 2'd0;
  localparam logic [1:0] MODE_SMP   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] REG_WMODE   = 2'd0;
  localparam logic [1:0] REG_SHRAD   = 2'd1;
  localparam logic [1:0] REG_MASKRAD = 2'd2;
  localparam logic [1:0] REG_CHCNT   = 2'd3;

  localparam logic [RAD_W-1:0] SHRAD_RST   = 15'd3277;
  localparam logic [RAD_W-1:0] MASKRAD_RST = 15'd8192;
  localparam logic [CNT_W-1:0] CHCNT_RST   = 7'd64;

  typedef enum logic [1:0] {DIV_INV, DIV_SHA, DIV_SHB, DIV_FIN} div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MASK,
    S_P1_RD, S_P1_SQ, S_P1_D2, S_P1_CHK,
    S_P2_RD, S_P2_SQ, S_P2_D2, S_P2_W,
    S_P2_INV, S_P2_SQRT, S_P2_RDSQ, S_P2_DIVA, S_P2_SHB, S_P2_DIVB,
    S_P2_MUL, S_P2_ACC, S_FIN, S_FIN_DIV
  } state_t;

  typedef struct packed {
    logic     load;
    logic     load_q;
    logic     clr_k;
    logic     inc_k;
    logic     mem_rd;
    logic     sq;
    logic     d2_lat;
    logic     div_start;
    div_sel_t div_sel;
    logic     sqrt_start;
    logic     rdsq;
    logic     a_take;
    logic     w_take;
    logic     w_zero;
    logic     mul;
    logic     acc;
    logic     out_mask;
    logic     out_hit;
    logic     out_est;
    logic     out_zero;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic n_zero;
    logic d2_zero;
    logic k_last;
    logic div_busy;
    logic div_done;
    logic sqrt_done;
    logic d2_ge_rr;
    logic sum_w_zero;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/idi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idi_div
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------------
module idi_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [idi_pkg::DVD_W-1:0]    dividend,
  input  logic [idi_pkg::DSR_W-1:0]    divisor,
  input  logic [idi_pkg::STP_W-1:0]    steps,
  output logic                         busy,
  output logic                         done,
  output logic [idi_pkg::DVD_W-1:0]    quot
);

  logic [idi_pkg::DSR_W-1:0] rem;
  logic [idi_pkg::DSR_W-1:0] dsr;
  logic [idi_pkg::DVD_W-1:0] dvd;
  logic [idi_pkg::STP_W-1:0] cnt;
  logic [idi_pkg::DSR_W:0]   rem_sh;
  logic [idi_pkg::DSR_W:0]   diff;
  logic                      ge;

  assign rem_sh = {rem, dvd[idi_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};
  assign diff   = rem_sh - {1'b0, dsr};
  assign quot   = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[idi_pkg::DSR_W-1:0] : rem_sh[idi_pkg::DSR_W-1:0];
      dvd <= {dvd[idi_pkg::DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/idi_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idi_sqrt
// Integer square root of a 30 bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module idi_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [29:0] radicand,
  output logic        done,
  output logic [14:0] root
);

  logic        busy;
  logic [29:0] nr;
  logic [29:0] r;
  logic [29:0] bitv;
  logic [30:0] trial;

  assign trial = {1'b0, r} + {1'b0, bitv};
  assign root  = r[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv == 30'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nr   <= radicand;
      r    <= '0;
      bitv <= 30'd1 << 28;
    end else if (busy) begin
      if ({1'b0, nr} >= trial) begin
        nr <= 30'({1'b0, nr} - trial);
        r  <= (r >> 1) + bitv;
      end else begin
        r  <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/idi_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idi_datapath
// Channel stores, distance and weight arithmetic, sums and result register.
// ----------------------------------------------------------------------------
module idi_datapath #(
  parameter int MAX_CHANNELS = idi_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  idi_pkg::cmd_t                     cmd,
  output idi_pkg::status_t                  st,
  input  logic [1:0]                        mode,
  input  logic [5:0]                        channel_index,
  input  logic signed [idi_pkg::CRD_W-1:0]  coord_x,
  input  logic signed [idi_pkg::CRD_W-1:0]  coord_y,
  input  logic signed [idi_pkg::VAL_W-1:0]  sample_value,
  input  logic [idi_pkg::RAD_W-1:0]         shepard_radius,
  input  logic [idi_pkg::RAD_W-1:0]         mask_radius,
  input  logic [idi_pkg::CNT_W-1:0]         channel_count,
  output logic                              done,
  output logic signed [idi_pkg::VAL_W-1:0]  estimate,
  output logic                              outside_mask
);

  localparam int AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW  = $clog2(MAX_CHANNELS + 1);
  localparam int SWW = idi_pkg::WGT_W + NW;

  logic [idi_pkg::CRD_W-1:0] pos_x [MAX_CHANNELS];
  logic [idi_pkg::CRD_W-1:0] pos_y [MAX_CHANNELS];
  logic [idi_pkg::VAL_W-1:0] smp   [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]   smp_vld;

  logic signed [idi_pkg::CRD_W-1:0] qx, qy;
  logic [30:0]                      qsqx, qsqy;
  logic [29:0]                      mm, rr;
  logic [NW-1:0]                    n;
  logic [NW-1:0]                    k;
  logic [idi_pkg::CRD_W-1:0]        px_rd, py_rd;
  logic signed [idi_pkg::VAL_W-1:0] smp_rd;
  logic signed [16:0]               dx, dy;
  logic signed [33:0]               dx2, dy2;
  logic [31:0]                      dxsq, dysq;
  logic [idi_pkg::D2_W-1:0]         d2;
  logic [29:0]                      rdsq;
  logic [14:0]                      rmd;
  logic [20:0]                      a;
  logic [idi_pkg::WGT_W-1:0]        w;
  logic signed [56:0]               prod;
  logic [SWW-1:0]                   sum_w;
  logic signed [63:0]               sum_wv;
  logic                             neg;
  logic [idi_pkg::DVD_W-1:0]        mag;
  logic [idi_pkg::DVD_W-1:0]        dividend;
  logic [idi_pkg::DSR_W-1:0]        divisor;
  logic [idi_pkg::STP_W-1:0]        steps;
  logic [idi_pkg::DVD_W-1:0]        quot;
  logic                             div_busy, div_done;
  logic                             sqrt_done;
  logic [14:0]                      root;
  logic signed [31:0]               qx2, qy2;
  logic [8:0]                       idx_ext;
  logic [31:0]                      neg_q;

  assign idx_ext = {3'b000, channel_index};
  assign n = ({25'd0, channel_count} > MAX_CHANNELS) ? NW'(MAX_CHANNELS)
                                                     : NW'(channel_count);

  // channel stores
  always_ff @(posedge clk) begin
    if (cmd.load && 32'(idx_ext) < MAX_CHANNELS) begin
      if (mode == idi_pkg::MODE_POS) begin
        pos_x[idx_ext[AW-1:0]] <= coord_x;
        pos_y[idx_ext[AW-1:0]] <= coord_y;
      end else begin
        smp[idx_ext[AW-1:0]] <= sample_value;
      end
    end
    if (cmd.mem_rd) begin
      px_rd  <= pos_x[k[AW-1:0]];
      py_rd  <= pos_y[k[AW-1:0]];
      smp_rd <= smp_vld[k[AW-1:0]] ? smp[k[AW-1:0]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_vld <= '0;
    end else if (cmd.load && mode == idi_pkg::MODE_SMP && 32'(idx_ext) < MAX_CHANNELS) begin
      smp_vld[idx_ext[AW-1:0]] <= 1'b1;
    end
  end

  // query capture and radius squares
  assign qx2 = coord_x * coord_x;
  assign qy2 = coord_y * coord_y;

  always_ff @(posedge clk) begin
    mm <= mask_radius * mask_radius;
    rr <= shepard_radius * shepard_radius;
    if (cmd.load_q) begin
      qx   <= coord_x;
      qy   <= coord_y;
      qsqx <= qx2[30:0];
      qsqy <= qy2[30:0];
    end
  end

  // distance to the current channel
  assign dx  = $signed({px_rd[15], px_rd}) - $signed({qx[15], qx});
  assign dy  = $signed({py_rd[15], py_rd}) - $signed({qy[15], qy});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign rmd = shepard_radius - root;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      dxsq <= dx2[31:0];
      dysq <= dy2[31:0];
    end
    if (cmd.d2_lat) begin
      d2 <= {2'b00, dxsq} + {2'b00, dysq};
    end
    if (cmd.rdsq) begin
      rdsq <= rmd * rmd;
    end
    if (cmd.a_take) begin
      a <= quot[20:0];
    end
    if (cmd.w_zero) begin
      w <= '0;
    end else if (cmd.w_take) begin
      w <= (|quot[idi_pkg::DVD_W-1:idi_pkg::WGT_W]) ? '1 : quot[idi_pkg::WGT_W-1:0];
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, w}) * smp_rd;
    end
  end

  // channel counter and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      sum_w  <= '0;
      sum_wv <= '0;
    end else begin
      if (cmd.clr_k) begin
        k      <= '0;
        sum_w  <= '0;
        sum_wv <= '0;
      end else begin
        if (cmd.inc_k) begin
          k <= k + 1'b1;
        end
        if (cmd.acc) begin
          sum_w  <= sum_w + SWW'(w);
          sum_wv <= sum_wv + {{7{prod[56]}}, prod};
        end
      end
    end
  end

  // operands of the shared divider
  assign neg = sum_wv[63];
  assign mag = neg ? (~sum_wv + 64'd1) : sum_wv;

  always_comb begin
    unique case (cmd.div_sel)
      idi_pkg::DIV_INV: begin
        dividend = {1'b1, 63'd0};
        divisor  = d2;
        steps    = idi_pkg::STEPS_INV;
      end
      idi_pkg::DIV_SHA: begin
        dividend = {rdsq, 34'd0};
        divisor  = {4'd0, rr};
        steps    = idi_pkg::STEPS_SHA;
      end
      idi_pkg::DIV_SHB: begin
        dividend = {a, 43'd0};
        divisor  = d2;
        steps    = idi_pkg::STEPS_SHB;
      end
      default: begin
        dividend = mag;
        divisor  = idi_pkg::DSR_W'(sum_w);
        steps    = idi_pkg::STEPS_FIN;
      end
    endcase
  end

  idi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .steps    (steps),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  idi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (d2[29:0]),
    .done     (sqrt_done),
    .root     (root)
  );

  // result register
  assign neg_q = ~quot[31:0] + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_mask | cmd.out_hit | cmd.out_est | cmd.out_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_mask || cmd.out_zero) begin
      estimate     <= '0;
      outside_mask <= cmd.out_mask;
    end else if (cmd.out_hit) begin
      estimate     <= smp_rd;
      outside_mask <= 1'b0;
    end else if (cmd.out_est) begin
      outside_mask <= 1'b0;
      if (!neg) begin
        estimate <= (quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
      end else begin
        estimate <= (quot > 64'h8000_0000) ? 32'sh8000_0000 : $signed(neg_q);
      end
    end
  end

  // status
  assign st.outside    = {1'b0, qsqx} + {1'b0, qsqy} >= {2'b00, mm};
  assign st.n_zero     = (n == '0);
  assign st.d2_zero    = (d2 == '0);
  assign st.k_last     = ((k + 1'b1) == n);
  assign st.div_busy   = div_busy;
  assign st.div_done   = div_done;
  assign st.sqrt_done  = sqrt_done;
  assign st.d2_ge_rr   = d2 >= {4'd0, rr};
  assign st.sum_w_zero = (sum_w == '0);

endmodule
`default_nettype wire

>>> hw/rtl/idi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idi_ctrl
// Sequencer: mask check, hit scan over the channels, weighting pass, final division.
// ----------------------------------------------------------------------------
module idi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       mode,
  input  logic             weight_mode,
  input  idi_pkg::status_t st,
  output idi_pkg::cmd_t    cmd,
  output logic             busy
);

  idi_pkg::state_t state, state_next;

  assign busy = (state != idi_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      idi_pkg::S_IDLE: begin
        if (start && mode == idi_pkg::MODE_QUERY) state_next = idi_pkg::S_MASK;
      end
      idi_pkg::S_MASK: begin
        priority if (st.outside) state_next = idi_pkg::S_IDLE;
        else if (st.n_zero)      state_next = idi_pkg::S_FIN;
        else                     state_next = idi_pkg::S_P1_RD;
      end
      idi_pkg::S_P1_RD: state_next = idi_pkg::S_P1_SQ;
      idi_pkg::S_P1_SQ: state_next = idi_pkg::S_P1_D2;
      idi_pkg::S_P1_D2: state_next = idi_pkg::S_P1_CHK;
      idi_pkg::S_P1_CHK: begin
        priority if (st.d2_zero) state_next = idi_pkg::S_IDLE;
        else if (st.k_last)      state_next = idi_pkg::S_P2_RD;
        else                     state_next = idi_pkg::S_P1_RD;
      end
      idi_pkg::S_P2_RD: state_next = idi_pkg::S_P2_SQ;
      idi_pkg::S_P2_SQ: state_next = idi_pkg::S_P2_D2;
      idi_pkg::S_P2_D2: state_next = idi_pkg::S_P2_W;
      idi_pkg::S_P2_W: begin
        priority if (!weight_mode) state_next = idi_pkg::S_P2_INV;
        else if (st.d2_ge_rr)      state_next = idi_pkg::S_P2_MUL;
        else                       state_next = idi_pkg::S_P2_SQRT;
      end
      idi_pkg::S_P2_INV: begin
        if (st.div_done) state_next = idi_pkg::S_P2_MUL;
      end
      idi_pkg::S_P2_SQRT: begin
        if (st.sqrt_done) state_next = idi_pkg::S_P2_RDSQ;
      end
      idi_pkg::S_P2_RDSQ: state_next = idi_pkg::S_P2_DIVA;
      idi_pkg::S_P2_DIVA: begin
        if (st.div_done) state_next = idi_pkg::S_P2_SHB;
      end
      idi_pkg::S_P2_SHB: state_next = idi_pkg::S_P2_DIVB;
      idi_pkg::S_P2_DIVB: begin
        if (st.div_done) state_next = idi_pkg::S_P2_MUL;
      end
      idi_pkg::S_P2_MUL: state_next = idi_pkg::S_P2_ACC;
      idi_pkg::S_P2_ACC: begin
        state_next = st.k_last ? idi_pkg::S_FIN : idi_pkg::S_P2_RD;
      end
      idi_pkg::S_FIN: begin
        state_next = st.sum_w_zero ? idi_pkg::S_IDLE : idi_pkg::S_FIN_DIV;
      end
      idi_pkg::S_FIN_DIV: begin
        if (st.div_done) state_next = idi_pkg::S_IDLE;
      end
      default: state_next = idi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = idi_pkg::DIV_INV;
    unique case (state)
      idi_pkg::S_IDLE: begin
        cmd.load   = start && (mode == idi_pkg::MODE_POS || mode == idi_pkg::MODE_SMP);
        cmd.load_q = start && (mode == idi_pkg::MODE_QUERY);
      end
      idi_pkg::S_MASK: begin
        cmd.out_mask = st.outside;
        cmd.clr_k    = !st.outside;
      end
      idi_pkg::S_P1_RD, idi_pkg::S_P2_RD: cmd.mem_rd = 1'b1;
      idi_pkg::S_P1_SQ, idi_pkg::S_P2_SQ: cmd.sq     = 1'b1;
      idi_pkg::S_P1_D2, idi_pkg::S_P2_D2: cmd.d2_lat = 1'b1;
      idi_pkg::S_P1_CHK: begin
        cmd.out_hit = st.d2_zero;
        cmd.clr_k   = !st.d2_zero && st.k_last;
        cmd.inc_k   = !st.d2_zero && !st.k_last;
      end
      idi_pkg::S_P2_W: begin
        cmd.div_start  = !weight_mode;
        cmd.div_sel    = idi_pkg::DIV_INV;
        cmd.w_zero     = weight_mode && st.d2_ge_rr;
        cmd.sqrt_start = weight_mode && !st.d2_ge_rr;
      end
      idi_pkg::S_P2_INV, idi_pkg::S_P2_DIVB: cmd.w_take = st.div_done;
      idi_pkg::S_P2_SQRT: cmd.rdsq = st.sqrt_done;
      idi_pkg::S_P2_RDSQ: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = idi_pkg::DIV_SHA;
      end
      idi_pkg::S_P2_DIVA: cmd.a_take = st.div_done;
      idi_pkg::S_P2_SHB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = idi_pkg::DIV_SHB;
      end
      idi_pkg::S_P2_MUL: cmd.mul = 1'b1;
      idi_pkg::S_P2_ACC: begin
        cmd.acc   = 1'b1;
        cmd.inc_k = !st.k_last;
      end
      idi_pkg::S_FIN: begin
        cmd.out_zero  = st.sum_w_zero;
        cmd.div_start = !st.sum_w_zero;
        cmd.div_sel   = idi_pkg::DIV_FIN;
      end
      idi_pkg::S_FIN_DIV: begin
        cmd.div_sel = idi_pkg::DIV_FIN;
        cmd.out_est = st.div_done;
      end
      default: ;
    endcase
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.out_mask, cmd.out_hit, cmd.out_est, cmd.out_zero}))
    else $error("more than one result command in a cycle");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !st.div_busy)
    else $error("divider started while busy");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == idi_pkg::MODE_QUERY) |=> busy)
    else $error("query accepted but sequencer stayed idle");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_hit || cmd.out_est || cmd.out_mask || cmd.out_zero) |=> !busy)
    else $error("sequencer did not return to idle after a result");

endmodule
`default_nettype wire

>>> hw/rtl/inverse_distance_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_distance_interpolator
// Inverse distance weighted estimate over scattered sensor channels.
//
//   channel   ports                                   transaction
//   input     start busy mode channel_index coord_x   start high, busy low
//             coord_y sample_value
//   result    done estimate outside_mask              done high, one cycle
//   config    psel penable pwrite paddr pwdata        psel penable pwrite
//             prdata pready                           (pready always high)
//
// loads are written in the cycle of acceptance; a query does a hit scan, then per
// channel a distance step and, for inverse square, one division, for Shepard inside
// the radius a square root and two divisions (neither beyond it), on the bit serial
// divider and square root unit, then a final division unless all weights are zero.
// a query that lands on a channel or outside the mask returns early.
// synchronous reset clears control and sample store valid bits, no sweep.
// the receiver cannot stall, done is a one cycle strobe.
// ----------------------------------------------------------------------------
module inverse_distance_interpolator #(
  parameter int MAX_CHANNELS = idi_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic [5:0]                        channel_index,
  input  logic signed [idi_pkg::CRD_W-1:0]  coord_x,
  input  logic signed [idi_pkg::CRD_W-1:0]  coord_y,
  input  logic signed [idi_pkg::VAL_W-1:0]  sample_value,
  output logic                              done,
  output logic signed [idi_pkg::VAL_W-1:0]  estimate,
  output logic                              outside_mask,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic                        weight_mode;
  logic [idi_pkg::RAD_W-1:0]   shepard_radius;
  logic [idi_pkg::RAD_W-1:0]   mask_radius;
  logic [idi_pkg::CNT_W-1:0]   channel_count;
  idi_pkg::cmd_t               cmd;
  idi_pkg::status_t            st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode    <= 1'b0;
      shepard_radius <= idi_pkg::SHRAD_RST;
      mask_radius    <= idi_pkg::MASKRAD_RST;
      channel_count  <= idi_pkg::CHCNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        idi_pkg::REG_WMODE:   weight_mode    <= pwdata[0];
        idi_pkg::REG_SHRAD:   shepard_radius <= pwdata[idi_pkg::RAD_W-1:0];
        idi_pkg::REG_MASKRAD: mask_radius    <= pwdata[idi_pkg::RAD_W-1:0];
        idi_pkg::REG_CHCNT:   channel_count  <= pwdata[idi_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      idi_pkg::REG_WMODE:   prdata = {31'd0, weight_mode};
      idi_pkg::REG_SHRAD:   prdata = {17'd0, shepard_radius};
      idi_pkg::REG_MASKRAD: prdata = {17'd0, mask_radius};
      idi_pkg::REG_CHCNT:   prdata = {25'd0, channel_count};
      default:              prdata = '0;
    endcase
  end

  idi_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .weight_mode (weight_mode),
    .st          (st),
    .cmd         (cmd),
    .busy        (busy)
  );

  idi_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .mode           (mode),
    .channel_index  (channel_index),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .sample_value   (sample_value),
    .shepard_radius (shepard_radius),
    .mask_radius    (mask_radius),
    .channel_count  (channel_count),
    .done           (done),
    .estimate       (estimate),
    .outside_mask   (outside_mask)
  );

endmodule
`default_nettype wire
